FILE: src/rlb_pkg.sv
// Shared types and constants for the RGB layer blender.
// Holds the blend mode codes and the rounded divide-by-255 helper.
// No dependencies.
package rlb_pkg;

    typedef enum logic [1:0] {
        MODE_MULTIPLY = 2'd0,
        MODE_SUBTRACT = 2'd1,
        MODE_SCREEN   = 2'd2,
        MODE_OVERLAY  = 2'd3
    } blend_mode_t;

    localparam int unsigned ChanWidth = 8;
    localparam int unsigned ProdWidth = 2 * ChanWidth;
    localparam logic [ChanWidth-1:0] ChanMax = 8'hFF;
    localparam logic [ProdWidth-1:0] RoundBias = 16'd127;

    // floor(y * Div255Mul / 2^Div255Shift) equals floor(y / 255) for y < 66052.
    localparam logic [16:0] Div255Mul = 17'd65794;
    localparam int unsigned Div255Shift = 24;
    localparam int unsigned RecipWidth = ProdWidth + 17;

    function automatic logic [ChanWidth-1:0] div255_round(input logic [ProdWidth-1:0] x);
        logic [ProdWidth-1:0]  y;
        logic [RecipWidth-1:0] p;
        y = x + RoundBias;
        p = RecipWidth'(y) * RecipWidth'(Div255Mul);
        return p[Div255Shift +: ChanWidth];
    endfunction

endpackage

FILE: src/rlb_lane.sv
// One color channel lane of the RGB layer blender.
// Registers the operand product and mode flags, then divides by 255 with rounding;
// subtract mode instead passes the registered clamped difference. Depends on rlb_pkg.
module rlb_lane import rlb_pkg::*; (
    input  logic                 aclk,
    input  logic                 load,
    input  blend_mode_t          mode,
    input  logic [ChanWidth-1:0] top,
    input  logic [ChanWidth-1:0] bottom,
    output logic [ChanWidth-1:0] result
);

    logic [ChanWidth-1:0] op_a;
    logic [ChanWidth-1:0] op_b;
    logic                 inv_next;
    logic                 sub_next;
    logic [ChanWidth-1:0] diff_next;

    logic [ProdWidth-1:0] prod_reg;
    logic                 inv_reg;
    logic                 sub_reg;
    logic [ChanWidth-1:0] diff_reg;
    logic [ChanWidth-1:0] quot;

    always_comb begin
        op_a      = top;
        op_b      = bottom;
        inv_next  = 1'b0;
        sub_next  = 1'b0;
        diff_next = (bottom > top) ? (bottom - top) : '0;
        case (mode)
            MODE_MULTIPLY: begin
                op_a = top;
                op_b = bottom;
            end
            MODE_SUBTRACT: begin
                sub_next = 1'b1;
            end
            MODE_SCREEN: begin
                op_a     = ~top;
                op_b     = ~bottom;
                inv_next = 1'b1;
            end
            MODE_OVERLAY: begin
                // Both halves double an operand that is at most 127, so it fits in 8 bits.
                if (bottom[ChanWidth-1]) begin
                    op_a     = ~top;
                    op_b     = {~bottom[ChanWidth-2:0], 1'b0};
                    inv_next = 1'b1;
                end else begin
                    op_a = top;
                    op_b = {bottom[ChanWidth-2:0], 1'b0};
                end
            end
            default: begin
                op_a = top;
                op_b = bottom;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= ProdWidth'(op_a) * ProdWidth'(op_b);
            inv_reg  <= inv_next;
            sub_reg  <= sub_next;
            diff_reg <= diff_next;
        end
    end

    assign quot = div255_round(prod_reg);

    always_comb begin
        if (sub_reg) begin
            result = diff_reg;
        end else if (inv_reg) begin
            result = ChanMax - quot;
        end else begin
            result = quot;
        end
    end

endmodule

FILE: src/rgb_layer_blend.sv
// Top level of the RGB layer blender: three channel lanes and the output stage.
// Throughput is one beat per cycle while the output is not stalled.
// The first register stage holds each lane's product, the second the merged pixel.
// Stall on the output holds the pipeline; two beats can be held while the output waits.
// Synchronous active-low reset empties both stages; data registers are not reset.
module rgb_layer_blend import rlb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic [ChanWidth-1:0] s_top_red,
    input  logic [ChanWidth-1:0] s_top_green,
    input  logic [ChanWidth-1:0] s_top_blue,
    input  logic [ChanWidth-1:0] s_bottom_red,
    input  logic [ChanWidth-1:0] s_bottom_green,
    input  logic [ChanWidth-1:0] s_bottom_blue,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ChanWidth-1:0] m_out_red,
    output logic [ChanWidth-1:0] m_out_green,
    output logic [ChanWidth-1:0] m_out_blue
);

    logic                 stg_valid_reg;
    logic                 stg_valid_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 load_stg;
    logic                 load_out;
    blend_mode_t          mode;
    logic [ChanWidth-1:0] lane_red;
    logic [ChanWidth-1:0] lane_green;
    logic [ChanWidth-1:0] lane_blue;
    logic [ChanWidth-1:0] red_reg;
    logic [ChanWidth-1:0] green_reg;
    logic [ChanWidth-1:0] blue_reg;

    assign mode     = blend_mode_t'(s_mode);
    assign load_out = stg_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !stg_valid_reg || load_out;
    assign load_stg = s_valid && s_ready;

    rlb_lane u_lane_red (
        .aclk   (aclk),
        .load   (load_stg),
        .mode   (mode),
        .top    (s_top_red),
        .bottom (s_bottom_red),
        .result (lane_red)
    );

    rlb_lane u_lane_green (
        .aclk   (aclk),
        .load   (load_stg),
        .mode   (mode),
        .top    (s_top_green),
        .bottom (s_bottom_green),
        .result (lane_green)
    );

    rlb_lane u_lane_blue (
        .aclk   (aclk),
        .load   (load_stg),
        .mode   (mode),
        .top    (s_top_blue),
        .bottom (s_bottom_blue),
        .result (lane_blue)
    );

    always_comb begin
        if (load_stg) begin
            stg_valid_next = 1'b1;
        end else if (load_out) begin
            stg_valid_next = 1'b0;
        end else begin
            stg_valid_next = stg_valid_reg;
        end
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            red_reg   <= lane_red;
            green_reg <= lane_green;
            blue_reg  <= lane_blue;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_red   = red_reg;
    assign m_out_green = green_reg;
    assign m_out_blue  = blue_reg;

    // A reset leaves no beat on the output.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // With both stages full and the output stalled, no new beat may enter.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_valid_reg && m_valid && !m_ready |-> !s_ready)
        else $error("input accepted into a full pipeline");

    // A stalled output beat keeps its pixel.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red)
            && $stable(m_out_green) && $stable(m_out_blue))
        else $error("stalled output beat changed");

    // An accepted beat, taken while the output is empty, is in the first stage on the next cycle.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> stg_valid_reg)
        else $error("accepted beat lost in the first stage");

endmodule
